FILE: src/ppm_pkg.sv
// ppm_pkg: shared types, constants and tables of the polynomial phase mixer.
// No dependencies.
package ppm_pkg;

  localparam int unsigned SampleWidthDef = 16;
  localparam int unsigned PhaseBitsDef   = 32;
  localparam int unsigned IndexWidthDef  = 32;

  // phase arithmetic is modulo 2^224, held as a row of 32-bit limbs
  localparam int unsigned LimbW    = 32;
  localparam int unsigned NumLimbs = 7;
  localparam int unsigned MacW     = LimbW * NumLimbs;
  localparam int unsigned MacCntW  = $clog2(MacW + 1);

  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned CfgDataW = 48;

  localparam logic [33:0] PiQ32 = 34'h3_243F_6A89;

  localparam logic [3:0] TrigLastSine = 4'd5;
  localparam logic [3:0] TrigLastStep = 4'd12;

  typedef enum logic [CfgAddrW-1:0] {
    CFG_START_TIME   = 3'd0,
    CFG_SAMPLE_PER   = 3'd1,
    CFG_SKY_FREQ     = 3'd2,
    CFG_COEFF_LIN    = 3'd3,
    CFG_COEFF_QUAD   = 3'd4,
    CFG_OFFSET_FREQ  = 3'd5
  } ppm_cfg_e;

  typedef enum logic [2:0] {
    OP_TIME  = 3'd0,
    OP_TSQ   = 3'd1,
    OP_TCUBE = 3'd2,
    OP_FA    = 3'd3,
    OP_PLIN  = 3'd4,
    OP_FQ    = 3'd5,
    OP_PQUAD = 3'd6,
    OP_POFS  = 3'd7
  } ppm_op_e;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'd0,
    ST_LAUNCH = 3'd1,
    ST_WAIT   = 3'd2,
    ST_ROTATE = 3'd3,
    ST_TRIG   = 3'd4,
    ST_MULT   = 3'd5,
    ST_ROUND  = 3'd6
  } ppm_state_e;

  typedef enum logic [2:0] {
    TG_IDLE   = 3'd0,
    TG_THETA  = 3'd1,
    TG_SQUARE = 3'd2,
    TG_INIT   = 3'd3,
    TG_MUL    = 3'd4,
    TG_RECIP  = 3'd5,
    TG_FIX    = 3'd6,
    TG_DONE   = 3'd7
  } ppm_trig_state_e;

  typedef struct packed {
    logic load;
    logic step;
  } ppm_cell_ctrl_t;

  // series divisor (n-1)*n per step: sine steps first, then cosine
  function automatic logic [7:0] trig_div(input logic [3:0] k);
    logic [7:0] d;
    unique case (k)
      4'd0:    d = 8'd6;
      4'd1:    d = 8'd20;
      4'd2:    d = 8'd42;
      4'd3:    d = 8'd72;
      4'd4:    d = 8'd110;
      4'd5:    d = 8'd156;
      4'd6:    d = 8'd2;
      4'd7:    d = 8'd12;
      4'd8:    d = 8'd30;
      4'd9:    d = 8'd56;
      4'd10:   d = 8'd90;
      4'd11:   d = 8'd132;
      4'd12:   d = 8'd182;
      default: d = 8'd1;
    endcase
    return d;
  endfunction

  // floor(2^32 / divisor)
  function automatic logic [31:0] trig_recip(input logic [3:0] k);
    logic [31:0] m;
    unique case (k)
      4'd0:    m = 32'd715827882;
      4'd1:    m = 32'd214748364;
      4'd2:    m = 32'd102261126;
      4'd3:    m = 32'd59652323;
      4'd4:    m = 32'd39045157;
      4'd5:    m = 32'd27531841;
      4'd6:    m = 32'd2147483648;
      4'd7:    m = 32'd357913941;
      4'd8:    m = 32'd143165576;
      4'd9:    m = 32'd76695844;
      4'd10:   m = 32'd47721858;
      4'd11:   m = 32'd32537631;
      4'd12:   m = 32'd23598721;
      default: m = 32'd0;
    endcase
    return m;
  endfunction

endpackage

FILE: src/ppm_mac_cell.sv
// ppm_mac_cell: one 32-bit limb of the bit-serial multiply-accumulate row.
// Depends on ppm_pkg.
module ppm_mac_cell
  import ppm_pkg::*;
(
  input  logic             clk_i,
  input  ppm_cell_ctrl_t   ctrl_i,
  input  logic [LimbW-1:0] acc_init_i,
  input  logic [LimbW-1:0] x_init_i,
  input  logic             add_i,
  input  logic             carry_i,
  input  logic             x_shift_i,
  output logic             carry_o,
  output logic             x_msb_o,
  output logic [LimbW-1:0] acc_o
);

  logic [LimbW-1:0] acc_q, acc_d;
  logic [LimbW-1:0] x_q, x_d;
  logic [LimbW:0]   sum;

  assign sum     = {1'b0, acc_q} + {1'b0, (add_i ? x_q : '0)} + {{LimbW{1'b0}}, carry_i};
  assign carry_o = sum[LimbW];
  assign x_msb_o = x_q[LimbW-1];
  assign acc_o   = acc_q;

  always_comb begin
    acc_d = acc_q;
    x_d   = x_q;
    if (ctrl_i.load) begin
      acc_d = acc_init_i;
      x_d   = x_init_i;
    end else if (ctrl_i.step) begin
      acc_d = sum[LimbW-1:0];
      x_d   = {x_q[LimbW-2:0], x_shift_i};
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    x_q   <= x_d;
  end

endmodule

FILE: src/ppm_serial_mac.sv
// ppm_serial_mac: acc + x*y modulo 2^224, one bit of y per cycle.
// Row of ppm_mac_cell limbs; depends on ppm_pkg.
module ppm_serial_mac
  import ppm_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [MacW-1:0]    acc_init_i,
  input  logic [MacW-1:0]    x_init_i,
  input  logic [MacW-1:0]    y_init_i,
  input  logic [MacCntW-1:0] n_iter_i,
  output logic               done_o,
  output logic [MacW-1:0]    result_o
);

  logic               busy_q;
  logic [MacCntW-1:0] cnt_q;
  logic [MacW-1:0]    y_q;
  ppm_cell_ctrl_t     ctrl;
  logic [NumLimbs:0]  carry;
  logic [NumLimbs:0]  xbit;

  assign ctrl.load = start_i;
  assign ctrl.step = busy_q && (cnt_q != '0);
  assign done_o    = busy_q && (cnt_q == '0);
  assign carry[0]  = 1'b0;
  assign xbit[0]   = 1'b0;

  for (genvar g = 0; g < NumLimbs; g++) begin : g_cell
    ppm_mac_cell u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl),
      .acc_init_i (acc_init_i[g*LimbW +: LimbW]),
      .x_init_i   (x_init_i[g*LimbW +: LimbW]),
      .add_i      (y_q[0]),
      .carry_i    (carry[g]),
      .x_shift_i  (xbit[g]),
      .carry_o    (carry[g+1]),
      .x_msb_o    (xbit[g+1]),
      .acc_o      (result_o[g*LimbW +: LimbW])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= n_iter_i;
    end else if (ctrl.step) begin
      cnt_q  <= cnt_q - 1'b1;
    end else if (done_o) begin
      busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      y_q <= y_init_i;
    end else if (ctrl.step) begin
      y_q <= {1'b0, y_q[MacW-1:1]};
    end
  end

endmodule

FILE: src/ppm_trig.sv
// ppm_trig: sine and cosine in Q30 of an angle in the first octant, Taylor series.
// Each series step runs through TG_MUL, TG_RECIP and TG_FIX; depends on ppm_pkg.
module ppm_trig
  import ppm_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [29:0]        angle_i,
  output logic               done_o,
  output logic signed [31:0] sin_o,
  output logic signed [31:0] cos_o
);

  ppm_trig_state_e   state_q, state_d;
  logic [29:0]       ang_q;
  logic [63:0]       mul_q;
  logic [29:0]       th_q;
  logic [29:0]       t2_q;
  logic [30:0]       term_q;
  logic [30:0]       v_q;
  logic [3:0]        k_q;
  logic signed [31:0] sin_q, cos_q;

  logic [30:0] q0, rem, quo;
  logic [38:0] q0d;
  logic [7:0]  div;

  assign div = trig_div(k_q);
  assign q0  = mul_q[62:32];
  assign q0d = 39'(q0) * 39'(div);
  assign rem = v_q - q0d[30:0];
  assign quo = (rem >= 31'(div)) ? q0 + 31'd1 : q0;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      TG_IDLE:   if (start_i) state_d = TG_THETA;
      TG_THETA:  state_d = TG_SQUARE;
      TG_SQUARE: state_d = TG_INIT;
      TG_INIT:   state_d = TG_MUL;
      TG_MUL:    state_d = TG_RECIP;
      TG_RECIP:  state_d = TG_FIX;
      TG_FIX:    state_d = (k_q == TrigLastStep) ? TG_DONE : TG_MUL;
      TG_DONE:   state_d = TG_IDLE;
      default:   state_d = TG_IDLE;
    endcase
  end

  always_comb begin
    done_o = (state_q == TG_DONE);
    sin_o  = sin_q;
    cos_o  = cos_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= TG_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      TG_IDLE: begin
        if (start_i) ang_q <= angle_i;
      end
      TG_THETA: begin
        mul_q <= 64'(ang_q) * 64'(PiQ32);
      end
      TG_SQUARE: begin
        th_q  <= mul_q[62:33];
        mul_q <= 64'(mul_q[62:33]) * 64'(mul_q[62:33]);
      end
      TG_INIT: begin
        t2_q   <= mul_q[59:30];
        term_q <= 31'(th_q);
        sin_q  <= signed'(32'(th_q));
        cos_q  <= 32'sh4000_0000;
        k_q    <= '0;
      end
      TG_MUL: begin
        mul_q <= 64'(term_q) * 64'(t2_q);
      end
      TG_RECIP: begin
        v_q   <= mul_q[60:30];
        mul_q <= 64'(mul_q[60:30]) * 64'(trig_recip(k_q));
      end
      TG_FIX: begin
        if (k_q <= TrigLastSine) begin
          sin_q <= k_q[0] ? sin_q + signed'(32'(quo)) : sin_q - signed'(32'(quo));
        end else begin
          cos_q <= k_q[0] ? cos_q + signed'(32'(quo)) : cos_q - signed'(32'(quo));
        end
        term_q <= (k_q == TrigLastSine) ? 31'h4000_0000 : quo;
        k_q    <= k_q + 4'd1;
      end
      TG_DONE: ;
      default: ;
    endcase
  end

endmodule

FILE: src/polynomial_phase_mixer.sv
// polynomial_phase_mixer: top level, sequencer, configuration and output stage.
// Depends on ppm_pkg, ppm_serial_mac (ppm_mac_cell) and ppm_trig.
//
// Usage: one real sample per input transaction on the s_axis group, tuser carrying
// the restart flag that zeroes the sample index before that sample. Each sample
// gives one output transaction on the m_axis group holding sample*cos(phase) and
// sample*sin(phase), rounded half up and saturated to SAMPLE_WIDTH.
// Configuration is to be written by the user over cfg_we_i/cfg_addr_i/cfg_wdata_i
// only while idle; the block itself does not enforce this. One sample is
// processed at a time. Its phase polynomial is formed by a row of seven 32-bit
// multiply-accumulate cells that consumes one multiplier bit per cycle over eight
// products. The Taylor sine/cosine unit follows, then the output multiply and
// round. A finished result waits in the output register while the next sample is
// taken. If the receiver stalls, the block finishes that sample and holds it until
// the output register frees. Reset clears the sample index and the control state
// and returns the configuration registers to zero, except sample_period, which
// resets to 1.
module polynomial_phase_mixer
  import ppm_pkg::*;
#(
  parameter int unsigned SAMPLE_WIDTH = SampleWidthDef,
  parameter int unsigned PHASE_BITS   = PhaseBitsDef,
  parameter int unsigned INDEX_WIDTH  = IndexWidthDef
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [CfgAddrW-1:0]                  cfg_addr_i,
  input  logic [CfgDataW-1:0]                  cfg_wdata_i,
  input  logic                                 s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  // sample_in
  input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]    s_axis_tdata_i,
  // restart
  input  logic                                 s_axis_tuser_i,
  output logic                                 m_axis_tvalid_o,
  input  logic                                 m_axis_tready_i,
  // out_real, out_imag
  output logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]  m_axis_tdata_o
);

  localparam int unsigned OutW   = ((2*SAMPLE_WIDTH+7)/8)*8;
  localparam int unsigned TimeW  = ((INDEX_WIDTH + 40 > 72) ? INDEX_WIDTH + 40 : 72) + 1;
  localparam int unsigned T2W    = (2*TimeW < MacW) ? 2*TimeW : MacW;
  localparam int unsigned Keep   = (PHASE_BITS < 32) ? PHASE_BITS : 32;
  localparam int unsigned ProdW  = SAMPLE_WIDTH + 32;
  localparam logic [31:0] PhMask = ~(32'hFFFF_FFFF >> Keep);
  localparam logic signed [ProdW:0] Half   = (ProdW+1)'(1) <<< 29;
  localparam logic signed [ProdW:0] SatMax = {{(ProdW+2-SAMPLE_WIDTH){1'b0}},
                                              {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic signed [ProdW:0] SatMin = ~SatMax;

  function automatic logic [SAMPLE_WIDTH-1:0] round_sat(input logic signed [ProdW-1:0] p);
    logic signed [ProdW:0] v;
    v = (signed'({p[ProdW-1], p}) + Half) >>> 30;
    if (v > SatMax) v = SatMax;
    if (v < SatMin) v = SatMin;
    return v[SAMPLE_WIDTH-1:0];
  endfunction

  // configuration registers
  logic [47:0] start_q;
  logic [39:0] period_q;
  logic [35:0] fsky_q;
  logic [47:0] a2_q, a3_q, fsn_q;

  ppm_state_e state_q, state_d;
  ppm_op_e    op_q;
  logic [INDEX_WIDTH-1:0] idx_q, idx_cur_q, idx_next;

  logic signed [SAMPLE_WIDTH-1:0] x_q;
  logic [TimeW-1:0] t_q;
  logic [T2W-1:0]   t2_q;
  logic [MacW-1:0]  t3_q, fa_q, fq_q, ph_q;

  logic               mac_start, mac_done;
  logic [MacW-1:0]    mac_acc, mac_x, mac_y, mac_res;
  logic [MacCntW-1:0] mac_n;
  logic [37:0]        fsky3;

  logic        trig_start, trig_done;
  logic signed [31:0] trig_sin, trig_cos, sn, cs;
  logic signed [31:0] c_q, s_q;
  logic [1:0]  quad_q;
  logic        swap_q;
  logic [31:0] u;
  logic [29:0] r30, angle;
  logic        swap;

  logic signed [ProdW-1:0] p_re_q, p_im_q;
  logic                    m_valid_q;
  logic [SAMPLE_WIDTH-1:0] out_re_q, out_im_q;
  logic                    in_acc, out_free;

  assign in_acc   = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free = !m_valid_q || m_axis_tready_i;
  assign idx_next = s_axis_tuser_i ? '0 : idx_q;
  assign fsky3    = {1'b0, fsky_q, 1'b0} + {2'b0, fsky_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q  <= '0;
      period_q <= 40'd1;
      fsky_q   <= '0;
      a2_q     <= '0;
      a3_q     <= '0;
      fsn_q    <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CFG_START_TIME:  start_q  <= cfg_wdata_i;
        CFG_SAMPLE_PER:  period_q <= cfg_wdata_i[39:0];
        CFG_SKY_FREQ:    fsky_q   <= cfg_wdata_i[35:0];
        CFG_COEFF_LIN:   a2_q     <= cfg_wdata_i;
        CFG_COEFF_QUAD:  a3_q     <= cfg_wdata_i;
        CFG_OFFSET_FREQ: fsn_q    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    mac_acc = '0;
    mac_x   = '0;
    mac_y   = '0;
    mac_n   = '0;
    unique case (op_q)
      OP_TIME: begin
        mac_acc = {{(MacW-72){1'b0}}, start_q, 24'b0};
        mac_x   = MacW'(period_q);
        mac_y   = MacW'(idx_cur_q);
        mac_n   = MacCntW'(INDEX_WIDTH);
      end
      OP_TSQ: begin
        mac_x = MacW'(t_q);
        mac_y = MacW'(t_q);
        mac_n = MacCntW'(TimeW);
      end
      OP_TCUBE: begin
        mac_x = MacW'(t2_q);
        mac_y = MacW'(t_q);
        mac_n = MacCntW'(TimeW);
      end
      OP_FA: begin
        mac_x = {{(MacW-113){a2_q[47]}}, a2_q, 65'b0};
        mac_y = MacW'(fsky_q);
        mac_n = MacCntW'(36);
      end
      OP_PLIN: begin
        mac_x = fa_q;
        mac_y = MacW'(t2_q);
        mac_n = MacCntW'(T2W);
      end
      OP_FQ: begin
        mac_x = {{(MacW-48){a3_q[47]}}, a3_q};
        mac_y = MacW'(fsky3);
        mac_n = MacCntW'(38);
      end
      OP_PQUAD: begin
        mac_acc = ph_q;
        mac_x   = fq_q;
        mac_y   = t3_q;
        mac_n   = MacCntW'(MacW);
      end
      OP_POFS: begin
        mac_acc = ph_q;
        mac_x   = {{(MacW-208){fsn_q[47]}}, fsn_q, 160'b0};
        mac_y   = MacW'(t_q);
        mac_n   = MacCntW'(TimeW);
      end
      default: ;
    endcase
  end

  ppm_serial_mac u_mac (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mac_start),
    .acc_init_i (mac_acc),
    .x_init_i   (mac_x),
    .y_init_i   (mac_y),
    .n_iter_i   (mac_n),
    .done_o     (mac_done),
    .result_o   (mac_res)
  );

  // top word of the negated phase sum
  assign u     = (~ph_q[MacW-1:MacW-32] + {31'b0, (ph_q[MacW-33:0] == '0)}) & PhMask;
  assign r30   = u[29:0];
  assign swap  = r30 > 30'h2000_0000;
  assign angle = swap ? 30'(31'h4000_0000 - {1'b0, r30}) : r30;

  ppm_trig u_trig (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (trig_start),
    .angle_i (angle),
    .done_o  (trig_done),
    .sin_o   (trig_sin),
    .cos_o   (trig_cos)
  );

  assign sn = swap_q ? trig_cos : trig_sin;
  assign cs = swap_q ? trig_sin : trig_cos;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (s_axis_tvalid_i) state_d = ST_LAUNCH;
      ST_LAUNCH: state_d = ST_WAIT;
      ST_WAIT:   if (mac_done) state_d = (op_q == OP_POFS) ? ST_ROTATE : ST_LAUNCH;
      ST_ROTATE: state_d = ST_TRIG;
      ST_TRIG:   if (trig_done) state_d = ST_MULT;
      ST_MULT:   state_d = ST_ROUND;
      ST_ROUND:  if (out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready_o = (state_q == ST_IDLE);
    mac_start       = (state_q == ST_LAUNCH);
    trig_start      = (state_q == ST_ROTATE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      op_q      <= OP_TIME;
      idx_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_acc) begin
        op_q  <= OP_TIME;
        idx_q <= idx_next + 1'b1;
      end else if (state_q == ST_WAIT && mac_done && op_q != OP_POFS) begin
        op_q <= ppm_op_e'(op_q + 3'd1);
      end
      if (state_q == ST_ROUND && out_free) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      x_q       <= signed'(s_axis_tdata_i[SAMPLE_WIDTH-1:0]);
      idx_cur_q <= idx_next;
    end
    if (state_q == ST_WAIT && mac_done) begin
      unique case (op_q)
        OP_TIME:  t_q  <= mac_res[TimeW-1:0];
        OP_TSQ:   t2_q <= mac_res[T2W-1:0];
        OP_TCUBE: t3_q <= mac_res;
        OP_FA:    fa_q <= mac_res;
        OP_PLIN:  ph_q <= mac_res;
        OP_FQ:    fq_q <= mac_res;
        OP_PQUAD: ph_q <= mac_res;
        OP_POFS:  ph_q <= mac_res;
        default: ;
      endcase
    end
    if (state_q == ST_ROTATE) begin
      quad_q <= u[31:30];
      swap_q <= swap;
    end
    if (state_q == ST_TRIG && trig_done) begin
      unique case (quad_q)
        2'd0: begin c_q <= cs;  s_q <= sn;  end
        2'd1: begin c_q <= -sn; s_q <= cs;  end
        2'd2: begin c_q <= -cs; s_q <= -sn; end
        2'd3: begin c_q <= sn;  s_q <= -cs; end
        default: ;
      endcase
    end
    if (state_q == ST_MULT) begin
      p_re_q <= x_q * c_q;
      p_im_q <= x_q * s_q;
    end
    if (state_q == ST_ROUND && out_free) begin
      out_re_q <= round_sat(p_re_q);
      out_im_q <= round_sat(p_im_q);
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = OutW'({out_im_q, out_re_q});

endmodule

FILE: tb/tb.sv
// tb: self-checking stream testbench for polynomial_phase_mixer.
// Predicts each mixed output in exact wide fixed point and compares per transaction.
// Depends on ppm_pkg and the polynomial_phase_mixer RTL.
module tb;
  import ppm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CfgAddrW-1:0] CFG_UNMAPPED = 3'd6;
  localparam int WatchdogLimit = 6000;
  localparam int DrainCycles   = 900;

  typedef struct {
    logic signed [15:0] sample;
    logic               restart;
  } sample_t;

  typedef struct {
    logic signed [15:0] re;
    logic signed [15:0] im;
  } mix_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_addr_i = '0;
  logic [47:0] cfg_wdata_i = '0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [15:0] s_axis_tdata_i = '0;
  logic        s_axis_tuser_i = 1'b0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [31:0] m_axis_tdata_o;

  polynomial_phase_mixer u_dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // shadow configuration and sample index
  logic [47:0] start_time_q;
  logic [39:0] sample_period_q;
  logic [35:0] sky_freq_q;
  logic [47:0] coeff_lin_q, coeff_quad_q, offset_freq_q;
  logic [31:0] sample_index_q;

  sample_t pending_q[$];
  mix_t    expected_q[$];
  int      n_sent, n_checked, n_errors, n_restarts, n_phases, n_sat;
  int      quiet_cycles;
  bit      no_idle;

  function automatic void taylor_q30(input logic [63:0] th, output logic signed [63:0] sn,
                                     output logic signed [63:0] cs);
    logic [63:0] t2, term;
    bit sub;
    t2 = (th * th) >> 30;
    term = th;
    sn = th;
    sub = 1;
    for (int n = 3; n <= 13; n += 2) begin
      term = ((term * t2) >> 30) / ((n - 1) * n);
      sn = sub ? sn - term : sn + term;
      sub = !sub;
    end
    term = 64'd1 << 30;
    cs = 64'sd1 <<< 30;
    sub = 1;
    for (int n = 2; n <= 14; n += 2) begin
      term = ((term * t2) >> 30) / ((n - 1) * n);
      cs = sub ? cs - term : cs + term;
      sub = !sub;
    end
  endfunction

  function automatic logic signed [15:0] scale_round(input logic signed [15:0] x,
                                                     input logic signed [63:0] trig);
    logic signed [63:0] v;
    v = (64'(x) * trig + (64'sd1 <<< 29)) >>> 30;
    if (v > 64'sd32767) return 16'sh7FFF;
    if (v < -64'sd32768) return 16'sh8000;
    return v[15:0];
  endfunction

  function automatic mix_t mix_sample(input sample_t it);
    logic [223:0] t, t2, t3, acc;
    logic [31:0]  u, r;
    logic [1:0]   quad;
    logic signed [63:0] sn, cs, c_o, s_o;
    mix_t m;
    if (it.restart) sample_index_q = '0;
    t = (224'(start_time_q) << 24) + 224'(sample_index_q) * 224'(sample_period_q);
    t2 = t * t;
    t3 = t2 * t;
    acc = 224'(38'(3) * 38'(sky_freq_q)) * {{176{coeff_quad_q[47]}}, coeff_quad_q} * t3;
    acc += (224'(sky_freq_q) * {{176{coeff_lin_q[47]}}, coeff_lin_q} * t2) << 65;
    acc += ({{176{offset_freq_q[47]}}, offset_freq_q} * t) << 160;
    acc = -acc;
    u = acc[223:192];
    quad = u[31:30];
    r = {2'b00, u[29:0]};
    if (r > (32'd1 << 29))
      taylor_q30((64'((32'd1 << 30) - r) * 64'(PiQ32)) >> 33, cs, sn);
    else
      taylor_q30((64'(r) * 64'(PiQ32)) >> 33, sn, cs);
    case (quad)
      2'd0: begin c_o = cs; s_o = sn; end
      2'd1: begin c_o = -sn; s_o = cs; end
      2'd2: begin c_o = -cs; s_o = -sn; end
      default: begin c_o = sn; s_o = -cs; end
    endcase
    m.re = scale_round(it.sample, c_o);
    m.im = scale_round(it.sample, s_o);
    sample_index_q = sample_index_q + 1;
    return m;
  endfunction

  // sample driver
  int gap_cnt;
  always @(posedge clk_i or negedge rst_ni) begin
    sample_t it;
    bit hold;
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
      gap_cnt = 0;
    end else begin
      hold = s_axis_tvalid_i && !s_axis_tready_o;
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        it.sample = s_axis_tdata_i;
        it.restart = s_axis_tuser_i;
        expected_q.push_back(mix_sample(it));
        n_sent++;
      end
      if (!hold) begin
        if (gap_cnt > 0) begin
          gap_cnt--;
          s_axis_tvalid_i <= 1'b0;
        end else if (pending_q.size() > 0) begin
          it = pending_q.pop_front();
          s_axis_tdata_i <= it.sample;
          s_axis_tuser_i <= it.restart;
          s_axis_tvalid_i <= 1'b1;
          gap_cnt = no_idle ? 0 : $urandom_range(0, 17);
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
    end
  end

  // result monitor
  int stall_cnt;
  always @(posedge clk_i or negedge rst_ni) begin
    mix_t exp_m;
    logic signed [15:0] got_re, got_im;
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
      stall_cnt = 0;
    end else begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got_re = m_axis_tdata_o[15:0];
        got_im = m_axis_tdata_o[31:16];
        if (expected_q.size() == 0) begin
          n_errors++;
          if (n_errors <= 10) $display("unexpected output re=%0d im=%0d", got_re, got_im);
        end else begin
          exp_m = expected_q.pop_front();
          n_checked++;
          if (exp_m.re == 16'sh7FFF || exp_m.re == 16'sh8000) n_sat++;
          if (got_re !== exp_m.re || got_im !== exp_m.im) begin
            n_errors++;
            if (n_errors <= 10)
              $display("mismatch #%0d: exp re=%0d im=%0d got re=%0d im=%0d",
                       n_checked, exp_m.re, exp_m.im, got_re, got_im);
          end
        end
        stall_cnt = no_idle ? 0 : $urandom_range(0, 17);
      end else if (stall_cnt > 0) begin
        stall_cnt--;
      end
      m_axis_tready_i <= (stall_cnt == 0);
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
      quiet_cycles = 0;
    else if (rst_ni)
      quiet_cycles++;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("watchdog: no transaction for %0d cycles", WatchdogLimit);
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic cfg_write(input logic [2:0] addr, input logic [47:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= addr;
    cfg_wdata_i <= val;
    case (addr)
      CFG_START_TIME:  start_time_q = val;
      CFG_SAMPLE_PER:  sample_period_q = val[39:0];
      CFG_SKY_FREQ:    sky_freq_q = val[35:0];
      CFG_COEFF_LIN:   coeff_lin_q = val;
      CFG_COEFF_QUAD:  coeff_quad_q = val;
      CFG_OFFSET_FREQ: offset_freq_q = val;
      default: ;
    endcase
  endtask

  task automatic cfg_done();
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic wait_idle();
    while (pending_q.size() > 0 || expected_q.size() > 0 || s_axis_tvalid_i)
      @(posedge clk_i);
    n_phases++;
  endtask

  task automatic push(input logic [15:0] smp, input logic rs);
    sample_t it;
    it.sample = smp;
    it.restart = rs;
    if (rs) n_restarts++;
    pending_q.push_back(it);
  endtask

  function automatic logic [47:0] rnd48();
    return {$urandom, $urandom};
  endfunction

  task automatic random_burst(input int n);
    logic [15:0] smp;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 7))
        0: smp = 16'h7FFF;
        1: smp = 16'h8000;
        default: smp = $urandom;
      endcase
      push(smp, $urandom_range(0, 15) == 0);
    end
  endtask

  initial begin
    start_time_q = '0;
    sample_period_q = 40'd1;
    sky_freq_q = '0;
    coeff_lin_q = '0;
    coeff_quad_q = '0;
    offset_freq_q = '0;
    sample_index_q = '0;
    no_idle = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // zero phase after reset: outputs pass the sample through
    push(16'h7FFF, 1'b0);
    push(16'h8000, 1'b0);
    push(16'h0000, 1'b0);
    push(16'h0001, 1'b1);
    push(16'hFFFF, 1'b0);
    wait_idle();

    // half-turn phase at index one, full-scale negative sample saturates
    cfg_write(CFG_SAMPLE_PER, 48'h80_0000_0000);
    cfg_write(CFG_OFFSET_FREQ, 48'h100_0000);
    cfg_write(CFG_UNMAPPED, 48'hFFFF_FFFF_FFFF);
    cfg_done();
    push(16'h8000, 1'b1);
    push(16'h8000, 1'b0);
    push(16'h7FFF, 1'b0);
    push(16'h8000, 1'b1);
    push(16'h5555, 1'b0);
    wait_idle();

    // zero sample period, all terms active at their maxima
    cfg_write(CFG_START_TIME, 48'hFFFF_FFFF_FFFF);
    cfg_write(CFG_SAMPLE_PER, 48'h0);
    cfg_write(CFG_SKY_FREQ, 48'hF_FFFF_FFFF);
    cfg_write(CFG_COEFF_LIN, 48'h7FFF_FFFF_FFFF);
    cfg_write(CFG_COEFF_QUAD, 48'h7FFF_FFFF_FFFF);
    cfg_write(CFG_OFFSET_FREQ, 48'h7FFF_FFFF_FFFF);
    cfg_done();
    push(16'h7FFF, 1'b0);
    push(16'h8000, 1'b0);
    push(16'h1234, 1'b1);
    wait_idle();

    // negative extremes, largest period
    cfg_write(CFG_SAMPLE_PER, 48'hFF_FFFF_FFFF);
    cfg_write(CFG_COEFF_LIN, 48'h8000_0000_0000);
    cfg_write(CFG_COEFF_QUAD, 48'h8000_0000_0000);
    cfg_write(CFG_OFFSET_FREQ, 48'h8000_0000_0000);
    cfg_done();
    push(16'h8000, 1'b1);
    push(16'h7FFF, 1'b0);
    push(16'hAAAA, 1'b0);
    push(16'h0001, 1'b0);
    wait_idle();

    // random settings
    for (int p = 0; p < 8; p++) begin
      no_idle = (p == 3);
      cfg_write(CFG_START_TIME, (p < 4) ? (rnd48() >> $urandom_range(0, 40)) : rnd48());
      cfg_write(CFG_SAMPLE_PER, (p == 5) ? 48'd1 : {8'd0, 8'($urandom_range(0, 255)),
                                                    $urandom} >> $urandom_range(0, 30));
      cfg_write(CFG_SKY_FREQ, rnd48() >> $urandom_range(12, 40));
      cfg_write(CFG_COEFF_LIN, rnd48());
      cfg_write(CFG_COEFF_QUAD, rnd48());
      cfg_write(CFG_OFFSET_FREQ, rnd48());
      cfg_done();
      random_burst(48);
      wait_idle();
    end
    no_idle = 0;

    repeat (DrainCycles) @(posedge clk_i);
    $display("Covered %0d samples (%0d restarts) over %0d register settings,", n_sent,
             n_restarts, n_phases);
    $display("%0d results checked, %0d with saturated real part, %0d mismatches.",
             n_checked, n_sat, n_errors);
    if (n_errors == 0 && expected_q.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end
endmodule
